// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define TCPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TCPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcps_pkg.sv -----
package tcps_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 20;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int DONE_W      = 32;

  localparam logic [CFG_W-1:0] RESET_TIME = CFG_W'(10);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_DONE   = 2'd1,
    EV_IDLE   = 2'd2,
    EV_REJECT = 2'd3
  } event_e;

  typedef enum logic {
    CFG_SERVICE_TIME = 1'b0,
    CFG_TICK_STEP    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                 op;
    logic [TAG_BITS-1:0] tag;
    logic                urgent;
  } cmd_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [TIME_W-1:0]   arrived;
  } slot_t;

  typedef struct packed {
    event_e              code;
    logic [TAG_BITS-1:0] tag;
    logic                urgent;
    logic [TIME_W-1:0]   waited;
    logic [CNT_W-1:0]    urg_cnt;
    logic [CNT_W-1:0]    nrm_cnt;
    logic                busy;
    logic [DONE_W-1:0]   done_urg;
    logic [DONE_W-1:0]   done_nrm;
    logic                last;
  } res_t;

endpackage

// ----- rtl/two_class_priority_service_scheduler_core.sv -----
// two-class strict priority scheduler with one server
//
// input side is a queue: an item (opcode, job_tag_i, urgent_flag_i) transfers when
// push is high and full is low; it lands in a two-entry command queue
// results come out of a four-entry queue: the oldest result sits on the
// result ports while empty is low and transfers when pop is high
// config writes (service time at index 0, tick step at index 1) transfer on
// cfg_valid_i with cfg_ready_o, which is always high
// the scheduler takes one command at a time: an arrival is handled in its
// transfer cycle (count check and write of the fifo ram); a tick that finds
// the server free or freeing up moves to the start state, which waits on the
// registered head read of the fifo ram; a reject or a completion is written
// to the result queue from the transfer cycle, a start or an idle result
// from the start state; the scheduler takes a command only when the result
// queue has room for two results, so a stalled receiver backs up into the
// command queue and then raises full
// reset empties all queues, zeroes time, counters and server state and
// loads 10 into both config registers; fifo rams are not cleared
`include "assert_macros.svh"

module two_class_priority_service_scheduler_core import tcps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic                opcode_i,
  input  logic [TAG_BITS-1:0] job_tag_i,
  input  logic                urgent_flag_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          event_code_o,
  output logic [TAG_BITS-1:0] result_tag_o,
  output logic                result_urgent_o,
  output logic [TIME_W-1:0]   waited_time_o,
  output logic [CNT_W-1:0]    urgent_waiting_o,
  output logic [CNT_W-1:0]    normal_waiting_o,
  output logic                server_busy_o,
  output logic [DONE_W-1:0]   done_urgent_total_o,
  output logic [DONE_W-1:0]   done_normal_total_o,
  output logic                last_of_run_o
);

  logic                  cmd_valid, cmd_pop, room, res_valid;
  cmd_t                  cmd;
  res_t                  res, head;
  logic [OUTQ_CNT_W-1:0] outq_cnt;

  tcps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .job_tag_i    (job_tag_i),
    .urgent_flag_i(urgent_flag_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  assign room = (outq_cnt <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

  tcps_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_ready_o(cfg_ready_o),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .room_i     (room),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tcps_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .empty      (empty),
    .pop        (pop),
    .head_o     (head),
    .cnt_o      (outq_cnt)
  );

  assign event_code_o        = head.code;
  assign result_tag_o        = head.tag;
  assign result_urgent_o     = head.urgent;
  assign waited_time_o       = head.waited;
  assign urgent_waiting_o    = head.urg_cnt;
  assign normal_waiting_o    = head.nrm_cnt;
  assign server_busy_o       = head.busy;
  assign done_urgent_total_o = head.done_urg;
  assign done_normal_total_o = head.done_nrm;
  assign last_of_run_o       = head.last;

  `TCPS_ASSERT(a_outq_bound, outq_cnt <= OUTQ_CNT_W'(OUTQ_DEPTH), "result queue overfilled")
  `TCPS_ASSERT_IMPL(a_no_write_full, res_valid, outq_cnt != OUTQ_CNT_W'(OUTQ_DEPTH), "full write")
  `TCPS_ASSERT_IMPL(a_start_busy, !empty && head.code == EV_START, server_busy_o, "idle start")
  `TCPS_ASSERT_IMPL(a_done_not_last, !empty && head.code == EV_DONE, !last_of_run_o, "done last")

endmodule

// ----- rtl/tcps_ram.sv -----
module tcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tcps_front.sv -----
module tcps_front import tcps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                opcode_i,
  input  logic [TAG_BITS-1:0] job_tag_i,
  input  logic                urgent_flag_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  // decode the item into a command; class is only meaningful on arrivals
  always_comb begin
    cmd_in.op     = op_e'(opcode_i);
    cmd_in.tag    = job_tag_i;
    cmd_in.urgent = urgent_flag_i & (cmd_in.op == OP_ARRIVAL);
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push & ~full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/tcps_outq.sv -----
module tcps_outq import tcps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  res_t                  res_i,
  output logic                  empty,
  input  logic                  pop,
  output res_t                  head_o,
  output logic [OUTQ_CNT_W-1:0] cnt_o
);

  res_t                  ent_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign empty  = (cnt_q == '0);
  assign do_pop = pop & ~empty;
  assign head_o = ent_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      ent_q[wr_ptr_q] <= res_i;
    end
  end

  // the scheduler only writes when space was reserved for it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_valid_i) begin
        wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUTQ_CNT_W'(res_valid_i) - OUTQ_CNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/tcps_engine.sv -----
module tcps_engine import tcps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             cfg_ready_o,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic             room_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_START = 2'b10
  } st_e;

  st_e               state_q, state_d;
  logic [PTR_W-1:0]  u_head_q, u_head_d, n_head_q, n_head_d;
  logic [CNT_W-1:0]  u_cnt_q, u_cnt_d, n_cnt_q, n_cnt_d;
  logic [TIME_W-1:0] clock_q, clock_d;
  logic              busy_q, busy_d;
  logic [TAG_BITS-1:0] srv_tag_q, srv_tag_d;
  logic              srv_urg_q, srv_urg_d;
  logic [CFG_W-1:0]  remain_q, remain_d;
  logic [DONE_W-1:0] done_u_q, done_u_d, done_n_q, done_n_d;
  logic [CFG_W-1:0]  svc_q, step_q;
  logic              sel_urg_q, sel_urg_d, sel_any_q, sel_any_d;

  logic              take;
  logic [CNT_W-1:0]  arr_cnt;
  logic [PTR_W-1:0]  arr_head;
  logic [SUM_W-1:0]  wsum;
  logic [PTR_W-1:0]  wpos;
  logic              u_we, n_we, rd_en;
  slot_t             wslot, u_rdata, n_rdata, head_slot;
  logic [TIME_W:0]   csum;
  logic              complete;

  tcps_ram #(.WIDTH($bits(slot_t)), .DEPTH(QUEUE_DEPTH)) u_urgent_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(wpos),
    .wdata_i(wslot),
    .re_i   (rd_en),
    .raddr_i(u_head_q),
    .rdata_o(u_rdata)
  );

  tcps_ram #(.WIDTH($bits(slot_t)), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(wpos),
    .wdata_i(wslot),
    .re_i   (rd_en),
    .raddr_i(n_head_q),
    .rdata_o(n_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign take        = (state_q == ST_IDLE) & cmd_valid_i & room_i;
  assign cmd_pop_o   = take;

  // tail slot of the fifo chosen by the arriving job
  always_comb begin
    arr_cnt  = cmd_i.urgent ? u_cnt_q : n_cnt_q;
    arr_head = cmd_i.urgent ? u_head_q : n_head_q;
    wsum     = SUM_W'(arr_head) + SUM_W'(arr_cnt);
    if (wsum >= SUM_W'(QUEUE_DEPTH)) begin
      wsum = wsum - SUM_W'(QUEUE_DEPTH);
    end
    wpos          = wsum[PTR_W-1:0];
    wslot.tag     = cmd_i.tag;
    wslot.arrived = clock_q;
  end

  assign csum      = {1'b0, clock_q} + (TIME_W + 1)'(step_q);
  assign complete  = busy_q & (remain_q <= step_q);
  assign head_slot = sel_urg_q ? u_rdata : n_rdata;

  always_comb begin
    state_d   = state_q;
    u_head_d  = u_head_q;
    n_head_d  = n_head_q;
    u_cnt_d   = u_cnt_q;
    n_cnt_d   = n_cnt_q;
    clock_d   = clock_q;
    busy_d    = busy_q;
    srv_tag_d = srv_tag_q;
    srv_urg_d = srv_urg_q;
    remain_d  = remain_q;
    done_u_d  = done_u_q;
    done_n_d  = done_n_q;
    sel_urg_d = sel_urg_q;
    sel_any_d = sel_any_q;
    u_we      = 1'b0;
    n_we      = 1'b0;
    rd_en     = 1'b0;
    res_valid_o  = 1'b0;
    res_o.code   = EV_IDLE;
    res_o.tag    = '0;
    res_o.urgent = 1'b0;
    res_o.waited = '0;
    res_o.last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            OP_ARRIVAL: begin
              if (arr_cnt == CNT_W'(QUEUE_DEPTH)) begin
                res_valid_o  = 1'b1;
                res_o.code   = EV_REJECT;
                res_o.tag    = cmd_i.tag;
                res_o.urgent = cmd_i.urgent;
              end else if (cmd_i.urgent) begin
                u_we    = 1'b1;
                u_cnt_d = u_cnt_q + CNT_W'(1);
              end else begin
                n_we    = 1'b1;
                n_cnt_d = n_cnt_q + CNT_W'(1);
              end
            end
            OP_TICK: begin
              clock_d = csum[TIME_W] ? '1 : csum[TIME_W-1:0];
              if (complete) begin
                busy_d   = 1'b0;
                remain_d = '0;
                if (srv_urg_q) begin
                  done_u_d = (done_u_q == '1) ? done_u_q : done_u_q + DONE_W'(1);
                end else begin
                  done_n_d = (done_n_q == '1) ? done_n_q : done_n_q + DONE_W'(1);
                end
                res_valid_o  = 1'b1;
                res_o.code   = EV_DONE;
                res_o.tag    = srv_tag_q;
                res_o.urgent = srv_urg_q;
                res_o.last   = 1'b0;
              end else if (busy_q) begin
                remain_d = remain_q - step_q;
              end
              // server free: fetch both heads and pick the class; the start state uses that head
              if (!busy_q || complete) begin
                rd_en     = 1'b1;
                sel_urg_d = (u_cnt_q != '0);
                sel_any_d = (u_cnt_q != '0) | (n_cnt_q != '0);
                state_d   = ST_START;
              end
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        state_d     = ST_IDLE;
        res_valid_o = 1'b1;
        if (sel_any_q) begin
          if (sel_urg_q) begin
            u_head_d = (u_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : u_head_q + PTR_W'(1);
            u_cnt_d  = u_cnt_q - CNT_W'(1);
          end else begin
            n_head_d = (n_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : n_head_q + PTR_W'(1);
            n_cnt_d  = n_cnt_q - CNT_W'(1);
          end
          busy_d       = 1'b1;
          srv_tag_d    = head_slot.tag;
          srv_urg_d    = sel_urg_q;
          remain_d     = svc_q;
          res_o.code   = EV_START;
          res_o.tag    = head_slot.tag;
          res_o.urgent = sel_urg_q;
          res_o.waited = clock_q - head_slot.arrived;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // snapshot fields show the state after the event
    res_o.urg_cnt  = u_cnt_d;
    res_o.nrm_cnt  = n_cnt_d;
    res_o.busy     = busy_d;
    res_o.done_urg = done_u_d;
    res_o.done_nrm = done_n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      u_head_q  <= '0;
      n_head_q  <= '0;
      u_cnt_q   <= '0;
      n_cnt_q   <= '0;
      clock_q   <= '0;
      busy_q    <= 1'b0;
      srv_tag_q <= '0;
      srv_urg_q <= 1'b0;
      remain_q  <= '0;
      done_u_q  <= '0;
      done_n_q  <= '0;
      sel_urg_q <= 1'b0;
      sel_any_q <= 1'b0;
      svc_q     <= RESET_TIME;
      step_q    <= RESET_TIME;
    end else begin
      state_q   <= state_d;
      u_head_q  <= u_head_d;
      n_head_q  <= n_head_d;
      u_cnt_q   <= u_cnt_d;
      n_cnt_q   <= n_cnt_d;
      clock_q   <= clock_d;
      busy_q    <= busy_d;
      srv_tag_q <= srv_tag_d;
      srv_urg_q <= srv_urg_d;
      remain_q  <= remain_d;
      done_u_q  <= done_u_d;
      done_n_q  <= done_n_d;
      sel_urg_q <= sel_urg_d;
      sel_any_q <= sel_any_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SERVICE_TIME: svc_q  <= cfg_data_i;
          CFG_TICK_STEP:    step_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
